FILE: src/integer_printf_formatter_defines.svh
// Assertion macros used by the formatter top level.
// Each macro checks a property clocked on i_clk and held off during reset.
`ifndef INTEGER_PRINTF_FORMATTER_DEFINES_SVH
`define INTEGER_PRINTF_FORMATTER_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication.
`define IPF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define IPF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define IPF_ASSERT_NOW(lbl, ante, cons, msg)
`define IPF_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: src/ipf_pkg.sv
`timescale 1ns / 1ps

package ipf_pkg;

    // conversion kinds as carried on the action field
    localparam logic [2:0] ACT_SDEC = 3'd0;
    localparam logic [2:0] ACT_UDEC = 3'd1;
    localparam logic [2:0] ACT_OCT  = 3'd2;
    localparam logic [2:0] ACT_HEXL = 3'd3;
    localparam logic [2:0] ACT_HEXU = 3'd4;

    typedef enum logic [1:0] {
        BASE_DEC,
        BASE_OCT,
        BASE_HEX
    } t_base;

    // ASCII codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_X_LO  = 8'h78;

    localparam logic [7:0] HEX_UPPER [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };
    localparam logic [7:0] HEX_LOWER [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    // q = (v * RECIP) >> RECIP_SHIFT is v / 10 for every v below 2^32
    localparam int          RECIP_BITS  = 32;
    localparam logic [31:0] RECIP       = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    typedef struct packed {
        logic load;   // take the input beat
        logic mul;    // form the reciprocal product
        logic digit;  // write one digit, replace magnitude by quotient
        logic prep;   // register the field layout
        logic emit;   // load one character into the output register
    } t_cmd;

    typedef struct packed {
        logic is_dec;     // current item converts in base ten
        logic quot_zero;  // the digit being written is the most significant
        logic out_free;   // output register can take a character
        logic last_pos;   // the next character closes the field
    } t_stat;

    function automatic logic [7:0] ipf_digit_char(input logic [3:0] d, input logic upper);
        return upper ? HEX_UPPER[d] : HEX_LOWER[d];
    endfunction

endpackage

FILE: src/ipf_ctrl.sv
`timescale 1ns / 1ps

module ipf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  ipf_pkg::t_stat i_stat,
    output ipf_pkg::t_cmd  o_cmd,
    output logic          o_in_ready
);
    import ipf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_DIGIT,
        S_PREP,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                if (i_stat.is_dec) begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_DIGIT;
                end else begin
                    o_cmd.digit = 1'b1;
                    if (i_stat.quot_zero) begin
                        n_state = S_PREP;
                    end
                end
            end
            S_DIGIT: begin
                o_cmd.digit = 1'b1;
                n_state     = i_stat.quot_zero ? S_PREP : S_CONV;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.last_pos) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_in_ready;

endmodule

FILE: src/ipf_dpath.sv
`timescale 1ns / 1ps

module ipf_dpath #(
    parameter int MAX_FIELD_WIDTH = 63,
    parameter int VALUE_BITS      = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ipf_pkg::t_cmd  i_cmd,
    output ipf_pkg::t_stat o_stat,
    input  logic [31:0]   i_value,
    input  logic [2:0]    i_action,
    input  logic          i_left_align,
    input  logic          i_force_sign,
    input  logic          i_space_sign,
    input  logic          i_alt_form,
    input  logic          i_zero_pad,
    input  logic [5:0]    i_field_width,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic [7:0]    o_character,
    output logic          o_last_char
);
    import ipf_pkg::*;

    localparam int MAX_DIGITS = (VALUE_BITS + 2) / 3;
    localparam int IDX_W      = $clog2(MAX_DIGITS);
    localparam int DCNT_W     = $clog2(MAX_DIGITS + 1);
    localparam int POS_W      = $clog2(MAX_FIELD_WIDTH + 1);
    localparam int PROD_W     = VALUE_BITS + RECIP_BITS;

    // decode of the input beat
    logic [VALUE_BITS-1:0] w_raw, w_mag;
    logic                  w_neg, w_nonzero, w_upper, w_sign_on;
    logic [7:0]            w_sign_char;
    logic [1:0]            w_plen;
    t_base                 w_base;
    logic [POS_W-1:0]      w_width;

    // item registers
    logic [VALUE_BITS-1:0] r_mag;
    logic [PROD_W-1:0]     r_prod;
    t_base                 r_base;
    logic                  r_upper, r_left, r_zpad, r_sign_on;
    logic [7:0]            r_sign_char;
    logic [1:0]            r_plen;
    logic [POS_W-1:0]      r_width;
    logic [DCNT_W-1:0]     r_dcnt;
    logic [3:0]            r_digs [MAX_DIGITS];

    // field layout: end of each region, in character positions
    logic [POS_W-1:0] r_b_lead, r_b_sign, r_b_pref, r_b_zero, r_b_dig, r_len, r_pos;

    logic [VALUE_BITS-1:0] w_quot, w_quot10, w_rem;
    logic [3:0]            w_dig;
    logic [POS_W-1:0]      w_total, w_pad, w_lead, w_zp;
    logic [POS_W-1:0]      n_b_sign, n_b_pref, n_b_zero, n_b_dig;
    logic [IDX_W-1:0]      w_didx;
    logic [7:0]            w_char;

    logic r_out_valid;
    logic [7:0] r_char;
    logic r_last;

    always_comb begin
        w_raw     = i_value[VALUE_BITS-1:0];
        w_nonzero = |w_raw;
        w_upper   = (i_action == ACT_HEXU);
        w_neg     = (i_action == ACT_SDEC) && w_raw[VALUE_BITS-1];
        w_mag     = w_neg ? VALUE_BITS'(~w_raw + 1'b1) : w_raw;
        case (i_action)
            ACT_OCT:            w_base = BASE_OCT;
            ACT_HEXL, ACT_HEXU: w_base = BASE_HEX;
            default:            w_base = BASE_DEC;
        endcase
        w_sign_on   = 1'b1;
        w_sign_char = CH_MINUS;
        if (!w_neg) begin
            if (i_action == ACT_SDEC && i_force_sign) begin
                w_sign_char = CH_PLUS;
            end else if (i_action == ACT_SDEC && i_space_sign) begin
                w_sign_char = CH_SPACE;
            end else begin
                w_sign_on = 1'b0;
            end
        end
        w_plen = 2'd0;
        if (i_alt_form && w_nonzero) begin
            if (w_base == BASE_OCT) begin
                w_plen = 2'd1;
            end else if (w_base == BASE_HEX) begin
                w_plen = 2'd2;
            end
        end
        w_width = (i_field_width > 6'(MAX_FIELD_WIDTH)) ? POS_W'(MAX_FIELD_WIDTH)
                                                       : POS_W'(i_field_width);
    end

    // one digit of the magnitude: shift for octal and hex, reciprocal for decimal
    always_comb begin
        w_quot10 = '0;
        w_rem    = '0;
        case (r_base)
            BASE_OCT: begin
                w_quot = r_mag >> 3;
                w_dig  = 4'(r_mag[2:0]);
            end
            BASE_HEX: begin
                w_quot = r_mag >> 4;
                w_dig  = r_mag[3:0];
            end
            default: begin
                w_quot   = VALUE_BITS'(r_prod >> RECIP_SHIFT);
                w_quot10 = (w_quot << 3) + (w_quot << 1);
                w_rem    = r_mag - w_quot10;
                w_dig    = w_rem[3:0];
            end
        endcase
    end

    always_comb begin
        w_total  = POS_W'(r_sign_on) + POS_W'(r_plen) + POS_W'(r_dcnt);
        w_pad    = (r_width > w_total) ? (r_width - w_total) : '0;
        w_lead   = (!r_left && !r_zpad) ? w_pad : '0;
        w_zp     = r_zpad ? w_pad : '0;
        n_b_sign = w_lead + POS_W'(r_sign_on);
        n_b_pref = n_b_sign + POS_W'(r_plen);
        n_b_zero = n_b_pref + w_zp;
        n_b_dig  = n_b_zero + POS_W'(r_dcnt);
    end

    // character at the current position; digits are stored least significant first
    always_comb begin
        w_didx = IDX_W'(r_b_dig - POS_W'(1) - r_pos);
        if (r_pos < r_b_lead) begin
            w_char = CH_SPACE;
        end else if (r_pos < r_b_sign) begin
            w_char = r_sign_char;
        end else if (r_pos < r_b_pref) begin
            w_char = (r_pos == r_b_sign) ? CH_ZERO : (r_upper ? CH_X_UP : CH_X_LO);
        end else if (r_pos < r_b_zero) begin
            w_char = CH_ZERO;
        end else if (r_pos < r_b_dig) begin
            w_char = ipf_digit_char(r_digs[w_didx], r_upper);
        end else begin
            w_char = CH_SPACE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag       <= w_mag;
            r_base      <= w_base;
            r_upper     <= w_upper;
            r_left      <= i_left_align;
            r_zpad      <= i_zero_pad && !i_left_align;
            r_sign_on   <= w_sign_on;
            r_sign_char <= w_sign_char;
            r_plen      <= w_plen;
            r_width     <= w_width;
            r_dcnt      <= '0;
            r_pos       <= '0;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_mag) * PROD_W'(RECIP);
        end
        if (i_cmd.digit) begin
            r_digs[r_dcnt[IDX_W-1:0]] <= w_dig;
            r_dcnt                    <= r_dcnt + DCNT_W'(1);
            r_mag                     <= w_quot;
        end
        if (i_cmd.prep) begin
            r_b_lead <= w_lead;
            r_b_sign <= n_b_sign;
            r_b_pref <= n_b_pref;
            r_b_zero <= n_b_zero;
            r_b_dig  <= n_b_dig;
            r_len    <= (r_width > w_total) ? r_width : w_total;
        end
        if (i_cmd.emit) begin
            r_char <= w_char;
            r_last <= o_stat.last_pos;
            r_pos  <= r_pos + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.is_dec    = (r_base == BASE_DEC);
    assign o_stat.quot_zero = (w_quot == '0);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_stat.last_pos  = (r_pos == r_len - POS_W'(1));

    assign o_out_valid = r_out_valid;
    assign o_character = r_char;
    assign o_last_char = r_last;

endmodule

FILE: src/integer_printf_formatter.sv
`timescale 1ns / 1ps
// Integer field formatter in the manner of printf %d %u %o %x %X.
// Input channel (i_in_valid / o_in_ready): one beat carries a value, the
// conversion kind, the five flags and a minimum field width.
// Output channel (o_out_valid / i_out_ready): one beat per ASCII character of
// the field, most significant part first; o_last_char marks the final beat.
// Steps per item: take the beat, then the digit loop (a reciprocal multiply
// and a digit write for each decimal digit, a shift and a digit write for
// each octal or hex digit), then lay out the field, then emit the characters
// while the receiver keeps up.
// The next item is taken while the final character still waits in the output
// register, so its digit loop overlaps the drain of the previous field.
// A stall on the output holds the current character and freezes the sequence;
// nothing is dropped or repeated. Synchronous active-low reset returns the
// controller to idle and empties the output register; no clearing pass.
module integer_printf_formatter #(
    parameter int MAX_FIELD_WIDTH = 63,
    parameter int VALUE_BITS      = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_value,
    input  logic [2:0]  i_action,
    input  logic        i_left_align,
    input  logic        i_force_sign,
    input  logic        i_space_sign,
    input  logic        i_alt_form,
    input  logic        i_zero_pad,
    input  logic [5:0]  i_field_width,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_character,
    output logic        o_last_char
);
    import ipf_pkg::*;

    `include "integer_printf_formatter_defines.svh"

    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencer: idle, digit loop, layout, character loop
    ipf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_ready (o_in_ready)
    );

    // magnitude, digit store, layout registers and output register
    ipf_dpath #(
        .MAX_FIELD_WIDTH (MAX_FIELD_WIDTH),
        .VALUE_BITS      (VALUE_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_value       (i_value),
        .i_action      (i_action),
        .i_left_align  (i_left_align),
        .i_force_sign  (i_force_sign),
        .i_space_sign  (i_space_sign),
        .i_alt_form    (i_alt_form),
        .i_zero_pad    (i_zero_pad),
        .i_field_width (i_field_width),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_character   (o_character),
        .o_last_char   (o_last_char)
    );

    // one item in flight: after taking a beat the input side closes
    `IPF_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready, "input open after accept")
    // a new item is only taken once any pending character is the last of its field
    `IPF_ASSERT_NOW(a_accept_at_field_end, o_in_ready && o_out_valid, o_last_char, "input open mid-field")
    // every character lies in the printable set the formatter can produce
    `IPF_ASSERT_NOW(a_char_range, o_out_valid, (o_character >= CH_SPACE) && (o_character <= CH_X_LO), "character out of range")

endmodule

FILE: sim/ipf_field_checker.sv
`timescale 1ns / 1ps

module ipf_field_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_value,
    input  logic [2:0]  i_action,
    input  logic        i_left_align,
    input  logic        i_force_sign,
    input  logic        i_space_sign,
    input  logic        i_alt_form,
    input  logic        i_zero_pad,
    input  logic [5:0]  i_field_width,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_character,
    input  logic        i_last_char,
    output int          o_fail_count,
    output int          o_pending
);
    import ipf_pkg::*;

    localparam int FIELD_CAP = 63;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char_beat;

    t_char_beat field_chars_q[$];
    int         mismatches = 0;

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        $display("MISMATCH at %0t: %s, expected 0x%02h got 0x%02h", $time, what, want, got);
        mismatches++;
    endtask

    // Lay out one field and queue its characters, last one marked.
    function automatic void predict_field(
        input logic [31:0] value,
        input logic [2:0]  action,
        input logic        left,
        input logic        fsign,
        input logic        ssign,
        input logic        alt,
        input logic        zpad_req,
        input logic [5:0]  width
    );
        logic [31:0] mag;
        logic [31:0] radix;
        logic [3:0]  d;
        logic [2:0]  kind;
        logic        zpad;
        logic        upper;
        logic        has_sign;
        logic [7:0]  sign_ch;
        logic [7:0]  prefix [2];
        logic [7:0]  digs [$];
        logic [7:0]  chars [$];
        int          plen;
        int          total;
        int          pad;
        t_char_beat  beat;

        mag      = value;
        kind     = (action > ACT_HEXU) ? ACT_UDEC : action;
        zpad     = zpad_req && !left;
        upper    = (kind == ACT_HEXU);
        radix    = 32'd10;
        has_sign = 1'b0;
        sign_ch  = CH_SPACE;
        plen     = 0;

        if (kind == ACT_SDEC) begin
            if (mag[31]) begin
                mag      = ~mag + 32'd1;
                has_sign = 1'b1;
                sign_ch  = CH_MINUS;
            end else if (fsign) begin
                has_sign = 1'b1;
                sign_ch  = CH_PLUS;
            end else if (ssign) begin
                has_sign = 1'b1;
                sign_ch  = CH_SPACE;
            end
        end else if (kind == ACT_OCT) begin
            radix = 32'd8;
            if (alt && mag != 0) begin
                prefix[0] = CH_ZERO;
                plen      = 1;
            end
        end else if (kind == ACT_HEXL || kind == ACT_HEXU) begin
            radix = 32'd16;
            if (alt && mag != 0) begin
                prefix[0] = CH_ZERO;
                prefix[1] = upper ? CH_X_UP : CH_X_LO;
                plen      = 2;
            end
        end

        // most significant digit ends up at the front
        if (mag == 0)
            digs.push_front(CH_ZERO);
        while (mag != 0) begin
            d   = 4'(mag % radix);
            digs.push_front(upper ? HEX_UPPER[d] : HEX_LOWER[d]);
            mag = mag / radix;
        end

        total = int'(has_sign) + plen + digs.size();
        pad   = (int'(width) > total) ? int'(width) - total : 0;

        if (!left && !zpad)
            repeat (pad) chars.push_back(CH_SPACE);
        if (has_sign)
            chars.push_back(sign_ch);
        for (int i = 0; i < plen; i++)
            chars.push_back(prefix[i]);
        if (zpad)
            repeat (pad) chars.push_back(CH_ZERO);
        foreach (digs[i])
            chars.push_back(digs[i]);
        if (left)
            repeat (pad) chars.push_back(CH_SPACE);

        while (chars.size() > FIELD_CAP)
            void'(chars.pop_back());
        foreach (chars[i]) begin
            beat.ch   = chars[i];
            beat.last = (i == chars.size() - 1);
            field_chars_q.push_back(beat);
        end
    endfunction

    // Check the output beat before queueing a new item: an item taken at
    // this edge cannot already be on the output.
    always @(posedge i_clk) begin : watch_beats
        t_char_beat want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (field_chars_q.size() == 0) begin
                    report_mismatch("character beat with none expected", 8'h00, i_character);
                end else begin
                    want = field_chars_q.pop_front();
                    if (i_character !== want.ch)
                        report_mismatch("character", want.ch, i_character);
                    if (i_last_char !== want.last)
                        report_mismatch("last_char", 8'(want.last), 8'(i_last_char));
                end
            end
            if (i_in_valid && i_in_ready)
                predict_field(i_value, i_action, i_left_align, i_force_sign, i_space_sign,
                              i_alt_form, i_zero_pad, i_field_width);
        end
        o_pending    <= field_chars_q.size();
        o_fail_count <= mismatches;
    end

endmodule

FILE: sim/tb_integer_printf_formatter.sv
`timescale 1ns / 1ps

module tb_integer_printf_formatter;
    import ipf_pkg::*;

    // Receiver hold-off long enough to fill the block and stall its input.
    localparam int HOLD_OFF_CYCLES = 400;
    // Cycles without any accepted beat before the run is declared hung;
    // several times the hold-off plus the longest field.
    localparam int WATCHDOG_LIMIT  = 5000;
    // Tail after the last expected character: one full item latency and more.
    localparam int DRAIN_CYCLES    = 100;
    localparam int ITEMS_PER_PHASE = 25;
    localparam int PRESSURE_ITEMS  = 10;

    // Flag bits in {left, plus, space, alt, zero} order.
    localparam logic [4:0] F_NONE  = 5'b00000;
    localparam logic [4:0] F_LEFT  = 5'b10000;
    localparam logic [4:0] F_PLUS  = 5'b01000;
    localparam logic [4:0] F_SPACE = 5'b00100;
    localparam logic [4:0] F_ALT   = 5'b00010;
    localparam logic [4:0] F_ZERO  = 5'b00001;

    typedef enum {
        PH_STEADY,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH,
        PH_PRESSURE
    } t_phase;

    typedef struct {
        logic [31:0] value;
        logic [2:0]  action;
        logic [4:0]  flags;
        logic [5:0]  field_width;
    } t_fmt_item;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic [31:0] i_value       = '0;
    logic [2:0]  i_action      = ACT_SDEC;
    logic        i_left_align  = 1'b0;
    logic        i_force_sign  = 1'b0;
    logic        i_space_sign  = 1'b0;
    logic        i_alt_form    = 1'b0;
    logic        i_zero_pad    = 1'b0;
    logic [5:0]  i_field_width = '0;
    logic        i_out_ready   = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [7:0]  o_character;
    logic        o_last_char;

    int     fail_count;
    int     chars_pending;
    t_phase phase = PH_STEADY;

    integer_printf_formatter DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_value       (i_value),
        .i_action      (i_action),
        .i_left_align  (i_left_align),
        .i_force_sign  (i_force_sign),
        .i_space_sign  (i_space_sign),
        .i_alt_form    (i_alt_form),
        .i_zero_pad    (i_zero_pad),
        .i_field_width (i_field_width),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_character   (o_character),
        .o_last_char   (o_last_char)
    );

    ipf_field_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_value       (i_value),
        .i_action      (i_action),
        .i_left_align  (i_left_align),
        .i_force_sign  (i_force_sign),
        .i_space_sign  (i_space_sign),
        .i_alt_form    (i_alt_form),
        .i_zero_pad    (i_zero_pad),
        .i_field_width (i_field_width),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_character   (o_character),
        .i_last_char   (o_last_char),
        .o_fail_count  (fail_count),
        .o_pending     (chars_pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Percentage of cycles in which the sender sits idle before a beat.
    function automatic int send_idle_pct(input t_phase ph);
        case (ph)
            PH_SEND_IDLE: return 49;
            PH_BOTH:      return 27;
            default:      return 0;
        endcase
    endfunction

    // Percentage of cycles in which the receiver drops ready.
    function automatic int recv_stall_pct(input t_phase ph);
        case (ph)
            PH_RECV_STALL: return 49;
            PH_BOTH:       return 27;
            default:       return 0;
        endcase
    endfunction

    function automatic t_fmt_item make_item(input logic [31:0] value, input logic [2:0] action,
                                            input logic [4:0] flags, input logic [5:0] width);
        t_fmt_item it;
        it.value       = value;
        it.action      = action;
        it.flags       = flags;
        it.field_width = width;
        return it;
    endfunction

    // Random item: bias values towards the interesting corners, keep most
    // widths small so fields stay short, and now and then use a spare code.
    function automatic t_fmt_item random_item();
        t_fmt_item it;
        case ($urandom_range(5))
            0:       it.value = $urandom_range(20);
            1:       it.value = 32'(-$urandom_range(20));
            2: begin
                case ($urandom_range(3))
                    0:       it.value = 32'h8000_0000;
                    1:       it.value = 32'h7FFF_FFFF;
                    2:       it.value = 32'hFFFF_FFFF;
                    default: it.value = 32'h0000_0000;
                endcase
            end
            3:       it.value = $urandom;
            default: it.value = $urandom >> $urandom_range(31);
        endcase
        if ($urandom_range(9) < 8)
            it.action = 3'($urandom_range(ACT_HEXU));
        else
            it.action = 3'($urandom_range(7, 5));
        it.flags = 5'($urandom_range(31));
        if ($urandom_range(3) == 0)
            it.field_width = 6'($urandom_range(63));
        else
            it.field_width = 6'($urandom_range(16));
        return it;
    endfunction

    // Offer one beat and hold it until taken. Valid stays high between
    // back-to-back beats; only an idle gap lowers it.
    task automatic send_item(input t_fmt_item it);
        logic gap;
        gap = ($urandom_range(99) < send_idle_pct(phase));
        if (gap) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct(phase))
                @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_value       <= it.value;
        i_action      <= it.action;
        i_left_align  <= it.flags[4];
        i_force_sign  <= it.flags[3];
        i_space_sign  <= it.flags[2];
        i_alt_form    <= it.flags[1];
        i_zero_pad    <= it.flags[0];
        i_field_width <= it.field_width;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    // Receiver: random stalls by phase, plus one long hold-off when the
    // pressure phase opens, counted here while the sender keeps offering.
    initial begin : receiver
        int  hold_left;
        logic hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever begin
            @(posedge i_clk);
            if (phase == PH_PRESSURE && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct(phase));
            end
        end
    end

    // Watchdog: end the run if no beat moves on either channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats: zero, extremes of the value, each conversion kind,
        // sign flags where they count and where they do not, prefixes on zero
        // and non-zero, left-align cancelling zero-pad, spare action codes,
        // widest field and content wider than the field.
        phase = PH_STEADY;
        send_item(make_item(32'h0000_0000, ACT_SDEC, F_NONE, 6'd0));
        send_item(make_item(32'h8000_0000, ACT_SDEC, F_NONE, 6'd0));
        send_item(make_item(32'h8000_0000, ACT_SDEC, F_PLUS | F_ZERO, 6'd3));
        send_item(make_item(32'h7FFF_FFFF, ACT_SDEC, F_PLUS, 6'd0));
        send_item(make_item(32'd5, ACT_SDEC, F_SPACE, 6'd8));
        send_item(make_item(32'd5, ACT_SDEC, F_PLUS | F_SPACE | F_ZERO, 6'd10));
        send_item(make_item(32'(-42), ACT_SDEC, F_ZERO, 6'd12));
        send_item(make_item(32'(-42), ACT_SDEC, F_LEFT | F_ZERO, 6'd12));
        send_item(make_item(32'd1, ACT_SDEC, F_PLUS | F_ZERO, 6'd63));
        send_item(make_item(32'hFFFF_FFFF, ACT_UDEC, F_PLUS | F_SPACE | F_ALT, 6'd63));
        send_item(make_item(32'd7, ACT_UDEC, F_ALT | F_ZERO, 6'd4));
        send_item(make_item(32'hFFFF_FFFF, ACT_OCT, F_ALT, 6'd0));
        send_item(make_item(32'h0000_0000, ACT_OCT, F_ALT, 6'd5));
        send_item(make_item(32'o17, ACT_OCT, F_ALT | F_ZERO, 6'd6));
        send_item(make_item(32'hDEAD_BEEF, ACT_HEXL, F_ALT | F_ZERO, 6'd16));
        send_item(make_item(32'hCAFE_BABE, ACT_HEXU, F_ALT | F_LEFT, 6'd20));
        send_item(make_item(32'h0000_0000, ACT_HEXU, F_ALT, 6'd3));
        send_item(make_item(32'h0000_00AB, ACT_HEXL, F_PLUS | F_SPACE, 6'd1));
        send_item(make_item(32'd1234, 3'd5, F_PLUS | F_ALT, 6'd0));
        send_item(make_item(32'h8000_0000, 3'd6, F_SPACE, 6'd11));
        send_item(make_item(32'hFFFF_FFFF, 3'd7, F_LEFT, 6'd63));
        send_item(make_item(32'h0000_0000, ACT_SDEC, F_LEFT | F_PLUS, 6'd63));

        // Random beats through each idling mix.
        for (int p = PH_STEADY; p <= PH_BOTH; p++) begin
            phase = t_phase'(p);
            repeat (ITEMS_PER_PHASE) send_item(random_item());
        end

        // Back-to-back beats against a long receiver hold-off.
        phase = PH_PRESSURE;
        repeat (PRESSURE_ITEMS) send_item(random_item());

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (chars_pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
